[rtl/utq_pkg.sv]
package utq_pkg;

    // default geometry of the message ring
    localparam int DEF_NUM_SLOTS = 8;
    localparam int DEF_SLOT_LEN  = 32;

    // input item opcodes
    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_TX_DONE = 1'b1
    } t_opcode;

    // input item as it arrives on the port
    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] char_value;
        logic       last_char;
    } t_in_item;

    // result item
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       busy_res;
        logic       dropped;
        logic [3:0] queued_count;
    } t_out_item;

    // classified item handed from the front end to the back end
    typedef struct packed {
        logic       is_load;
        logic       nonzero;
        logic       last;
        logic [7:0] ch;
    } t_cmd;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DATA,
        ST_NEXT
    } t_back_state;

endpackage

[rtl/utq_front.sv]
module utq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  utq_pkg::t_in_item i_in_item,
    output logic              o_cmd_valid,
    output utq_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);

    // two-entry queue of classified items
    utq_pkg::t_cmd r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_cnt;
    logic          push;
    logic          pop;
    utq_pkg::t_cmd cls;

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    // classify the incoming item
    always_comb begin
        cls.is_load = (i_in_item.opcode == utq_pkg::OP_LOAD);
        cls.nonzero = (i_in_item.char_value != 8'd0);
        cls.last    = i_in_item.last_char;
        cls.ch      = i_in_item.char_value;
    end

    // queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/utq_back.sv]
module utq_back #(
    parameter int NUM_SLOTS = utq_pkg::DEF_NUM_SLOTS,
    parameter int SLOT_LEN  = utq_pkg::DEF_SLOT_LEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  utq_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output utq_pkg::t_out_item o_out_item
);

    localparam int DEPTH = NUM_SLOTS * SLOT_LEN;
    localparam int SW    = $clog2(NUM_SLOTS);
    localparam int PW    = $clog2(SLOT_LEN);
    localparam int CW    = $clog2(NUM_SLOTS + 1);
    localparam int AW    = $clog2(DEPTH);

    // byte address of a position within a slot
    function automatic logic [AW-1:0] f_addr(input logic [SW-1:0] s, input logic [PW-1:0] p);
        return AW'(s) * AW'(SLOT_LEN) + AW'(p);
    endfunction

    // ring successor of a slot
    function automatic logic [SW-1:0] f_next(input logic [SW-1:0] s);
        return (s == SW'(NUM_SLOTS - 1)) ? '0 : s + SW'(1);
    endfunction

    // slot bytes and per-slot message lengths; a length marks the terminator
    logic [7:0]    r_data_mem [DEPTH];
    logic [PW-1:0] r_len_mem  [NUM_SLOTS];
    logic [7:0]    r_rd_data;
    logic [PW-1:0] r_rd_len;

    utq_pkg::t_back_state r_state, n_state;
    logic [SW-1:0] r_head, n_head;
    logic [SW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_sp, n_sp;
    logic [PW-1:0] r_lp, n_lp;
    logic [PW-1:0] r_head_len, n_head_len;
    logic          r_sending, n_sending;
    logic          r_mask, n_mask;
    logic          r_fwd, n_fwd;
    logic [7:0]    r_fwd_byte, n_fwd_byte;
    logic          r_out_valid, n_out_valid;
    utq_pkg::t_out_item r_out_item, n_out_item;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          len_wr_en;
    logic [SW-1:0] len_wr_addr;
    logic [PW-1:0] len_wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          len_rd_en;
    logic [SW-1:0] len_rd_addr;
    logic          res_load;
    logic          res_valid;
    logic [7:0]    res_byte;
    logic          res_dropped;
    logic          out_free;
    logic [SW-1:0] fill;
    logic [SW-1:0] nh;
    logic          store;
    logic [PW-1:0] lp_after;
    logic [CW-1:0] cnt_after;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign out_free    = !r_out_valid || i_out_ready;
    assign fill        = f_next(r_tail);
    assign nh          = f_next(r_head);
    assign store       = i_cmd.nonzero && (r_lp < PW'(SLOT_LEN - 1));
    assign lp_after    = store ? r_lp + PW'(1) : r_lp;
    assign cnt_after   = (r_count != '0) ? r_count - CW'(1) : r_count;

    // byte store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_data_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_data_mem[rd_addr];
        end
    end

    // length table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (len_wr_en) begin
            r_len_mem[len_wr_addr] <= len_wr_data;
        end
        if (len_rd_en) begin
            r_rd_len <= r_len_mem[len_rd_addr];
        end
    end

    // sequencer next state and datapath
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_sp        = r_sp;
        n_lp        = r_lp;
        n_head_len  = r_head_len;
        n_sending   = r_sending;
        n_mask      = r_mask;
        n_fwd       = r_fwd;
        n_fwd_byte  = r_fwd_byte;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        o_cmd_pop   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        len_wr_en   = 1'b0;
        len_wr_addr = '0;
        len_wr_data = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        len_rd_en   = 1'b0;
        len_rd_addr = '0;
        res_load    = 1'b0;
        res_valid   = 1'b0;
        res_byte    = '0;
        res_dropped = 1'b0;

        unique case (r_state)
            utq_pkg::ST_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.is_load) begin
                        if (r_count == CW'(NUM_SLOTS)) begin
                            // queue full: item dropped
                            res_load    = 1'b1;
                            res_dropped = 1'b1;
                        end else begin
                            wr_en   = store;
                            wr_addr = f_addr(fill, r_lp);
                            wr_data = i_cmd.ch;
                            n_lp    = lp_after;
                            if (i_cmd.last) begin
                                // commit the message
                                n_tail      = fill;
                                n_count     = r_count + CW'(1);
                                n_lp        = '0;
                                len_wr_en   = 1'b1;
                                len_wr_addr = fill;
                                len_wr_data = lp_after;
                                if (!r_sending) begin
                                    // idle transmitter: head is this slot, send first byte
                                    n_sending  = 1'b1;
                                    n_head_len = lp_after;
                                    n_sp       = r_sp + PW'(1);
                                    rd_en      = 1'b1;
                                    rd_addr    = f_addr(r_head, r_sp);
                                    n_mask     = (r_sp < lp_after);
                                    n_fwd      = store && (r_lp == r_sp);
                                    n_fwd_byte = i_cmd.ch;
                                    n_state    = utq_pkg::ST_DATA;
                                end else begin
                                    res_load = 1'b1;
                                end
                            end else begin
                                res_load = 1'b1;
                            end
                        end
                    end else if (!r_sending) begin
                        // spurious tx-done
                        res_load = 1'b1;
                    end else if (r_sp < r_head_len) begin
                        // next byte of the head message
                        rd_en   = 1'b1;
                        rd_addr = f_addr(r_head, r_sp);
                        n_sp    = r_sp + PW'(1);
                        n_mask  = 1'b1;
                        n_fwd   = 1'b0;
                        n_state = utq_pkg::ST_DATA;
                    end else begin
                        // terminator: retire the head message
                        n_count = cnt_after;
                        n_head  = nh;
                        n_sp    = '0;
                        if (cnt_after == '0) begin
                            n_sending = 1'b0;
                            res_load  = 1'b1;
                        end else begin
                            rd_en       = 1'b1;
                            rd_addr     = f_addr(nh, '0);
                            len_rd_en   = 1'b1;
                            len_rd_addr = nh;
                            n_sp        = PW'(1);
                            n_state     = utq_pkg::ST_NEXT;
                        end
                    end
                end
            end
            utq_pkg::ST_DATA: begin
                res_load  = 1'b1;
                res_valid = 1'b1;
                res_byte  = r_mask ? (r_fwd ? r_fwd_byte : r_rd_data) : 8'd0;
                n_state   = utq_pkg::ST_IDLE;
            end
            utq_pkg::ST_NEXT: begin
                n_head_len = r_rd_len;
                res_load   = 1'b1;
                res_valid  = 1'b1;
                res_byte   = (r_rd_len != '0) ? r_rd_data : 8'd0;
                n_state    = utq_pkg::ST_IDLE;
            end
            default: begin
                n_state = utq_pkg::ST_IDLE;
            end
        endcase

        // result register load
        if (res_load) begin
            n_out_valid             = 1'b1;
            n_out_item.tx_valid     = res_valid;
            n_out_item.tx_byte      = res_valid ? res_byte : 8'd0;
            n_out_item.busy_res     = n_sending;
            n_out_item.dropped      = res_dropped;
            n_out_item.queued_count = 4'(n_count);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= SW'(NUM_SLOTS - 1);
            r_count     <= '0;
            r_sp        <= '0;
            r_lp        <= '0;
            r_head_len  <= '0;
            r_sending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_sp        <= n_sp;
            r_lp        <= n_lp;
            r_head_len  <= n_head_len;
            r_sending   <= n_sending;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mask     <= n_mask;
        r_fwd      <= n_fwd;
        r_fwd_byte <= n_fwd_byte;
        r_out_item <= n_out_item;
    end

endmodule

[rtl/uart_tx_message_queue.sv]
// Results: an accepted item waits in the front-end queue; the back end then loads the
// result register, via a read state when the item sends a byte (registered store read).
// Throughput: one item per cycle without a byte read, when the result register is free;
// none is taken during a byte read, set by the registered read port of the slot store.
// Reset: synchronous, active low; clears pointers, counts and handshakes. The slot
// store is not cleared: a per-slot length table marks where each message ends.
module uart_tx_message_queue #(
    parameter int NUM_SLOTS = utq_pkg::DEF_NUM_SLOTS,
    parameter int SLOT_LEN  = utq_pkg::DEF_SLOT_LEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  utq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output utq_pkg::t_out_item o_out_item
);

    logic          cmd_valid;
    logic          cmd_pop;
    utq_pkg::t_cmd cmd;

    // front end: accept and classify items
    utq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // back end: message ring and transmit sequencing
    utq_back #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_LEN  (SLOT_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_SLOTS   = utq_pkg::DEF_NUM_SLOTS;
    localparam int SLOT_LEN    = utq_pkg::DEF_SLOT_LEN;
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int POS_W       = $clog2(SLOT_LEN) + 1;
    localparam int RAND_ITEMS  = 630;
    localparam int CALM_ITEMS  = 100;
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 2000;

    // one row of the directed table; want is used only where fixed is set
    typedef struct packed {
        utq_pkg::t_opcode   op;
        logic [7:0]         ch;
        logic               last;
        logic [7:0]         reps;
        logic               fixed;
        utq_pkg::t_out_item want;
    } t_stim_row;

    localparam int DIR_ROWS = 16;
    localparam t_stim_row DIR_TABLE [DIR_ROWS] = '{
        // tx-done with nothing in flight is ignored
        '{utq_pkg::OP_TX_DONE, 8'h00, 1'b0, 8'd1,  1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 4'd0}},
        // empty message still puts one zero byte out
        '{utq_pkg::OP_LOAD,    8'h00, 1'b1, 8'd1,  1'b1, {1'b1, 8'h00, 1'b1, 1'b0, 4'd1}},
        '{utq_pkg::OP_TX_DONE, 8'h00, 1'b0, 8'd1,  1'b1, {1'b0, 8'h00, 1'b0, 1'b0, 4'd0}},
        // over-long message: only SLOT_LEN-1 characters are kept
        '{utq_pkg::OP_LOAD,    8'hFF, 1'b0, 8'd40, 1'b0, '0},
        '{utq_pkg::OP_LOAD,    8'h01, 1'b1, 8'd1,  1'b1, {1'b1, 8'hFF, 1'b1, 1'b0, 4'd1}},
        '{utq_pkg::OP_TX_DONE, 8'h00, 1'b0, 8'd32, 1'b0, '0},
        // zero character in the middle is skipped
        '{utq_pkg::OP_LOAD,    8'h41, 1'b0, 8'd1,  1'b0, '0},
        '{utq_pkg::OP_LOAD,    8'h00, 1'b0, 8'd1,  1'b0, '0},
        '{utq_pkg::OP_LOAD,    8'h42, 1'b1, 8'd1,  1'b0, '0},
        // fill the ring, wrapping the tail
        '{utq_pkg::OP_LOAD,    8'h80, 1'b1, 8'd7,  1'b0, '0},
        // loads into a full ring are dropped and flagged
        '{utq_pkg::OP_LOAD,    8'h55, 1'b0, 8'd1,  1'b1, {1'b0, 8'h00, 1'b1, 1'b1, 4'd8}},
        '{utq_pkg::OP_LOAD,    8'h7F, 1'b1, 8'd1,  1'b1, {1'b0, 8'h00, 1'b1, 1'b1, 4'd8}},
        '{utq_pkg::OP_TX_DONE, 8'hFF, 1'b1, 8'd3,  1'b0, '0},
        // empty message committed while a transfer is running
        '{utq_pkg::OP_LOAD,    8'h00, 1'b1, 8'd1,  1'b0, '0},
        '{utq_pkg::OP_TX_DONE, 8'h00, 1'b0, 8'd24, 1'b0, '0},
        '{utq_pkg::OP_LOAD,    8'h7E, 1'b1, 8'd1,  1'b0, '0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    utq_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_ready;
    utq_pkg::t_out_item o_out_item;

    uart_tx_message_queue #(
        .NUM_SLOTS(NUM_SLOTS),
        .SLOT_LEN (SLOT_LEN)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predicted state of the message ring
    logic [7:0]        ring_bytes [NUM_SLOTS*SLOT_LEN];
    logic [SLOT_W-1:0] send_slot;
    logic [SLOT_W-1:0] commit_slot;
    logic [3:0]        msg_count;
    logic [POS_W-1:0]  send_pos;
    logic [POS_W-1:0]  fill_pos;
    logic              tx_active;

    utq_pkg::t_out_item pending_results [$];

    // shared between sender, receiver and checker
    bit                 calm;
    bit                 hold_req;
    bit                 fixed_flag;
    utq_pkg::t_out_item fixed_want;
    int                 useful_items;
    int                 results_seen;
    int                 drops_seen;
    int                 full_hits;
    int                 mismatches;

    function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] s);
        return (int'(s) == NUM_SLOTS - 1) ? '0 : s + 1'b1;
    endfunction

    // read one byte of a slot and clear it behind the reader
    function automatic logic [7:0] take_byte(logic [SLOT_W-1:0] s, logic [POS_W-1:0] p);
        int         idx;
        logic [7:0] b;
        if (int'(p) >= SLOT_LEN) return 8'h00;
        idx = int'(s) * SLOT_LEN + int'(p);
        b = ring_bytes[idx];
        ring_bytes[idx] = 8'h00;
        return b;
    endfunction

    // works out the result of one item and advances the predicted ring
    function automatic utq_pkg::t_out_item predict_tx_result(utq_pkg::t_in_item it);
        utq_pkg::t_out_item r;
        logic [SLOT_W-1:0]  fill;
        logic [7:0]         b;
        r = '0;
        if (it.opcode == utq_pkg::OP_LOAD) begin
            if (int'(msg_count) >= NUM_SLOTS) begin
                r.dropped = 1'b1;
            end else begin
                fill = next_slot(commit_slot);
                if (it.char_value != 8'h00 && int'(fill_pos) < SLOT_LEN - 1) begin
                    ring_bytes[int'(fill) * SLOT_LEN + int'(fill_pos)] = it.char_value;
                    fill_pos = fill_pos + 1'b1;
                end
                if (it.last_char) begin
                    commit_slot = fill;
                    msg_count   = msg_count + 1'b1;
                    fill_pos    = '0;
                    if (!tx_active) begin
                        r.tx_byte  = take_byte(send_slot, send_pos);
                        send_pos   = send_pos + 1'b1;
                        r.tx_valid = 1'b1;
                        tx_active  = 1'b1;
                    end
                end
            end
        end else if (tx_active) begin
            b = (int'(send_pos) < SLOT_LEN) ?
                ring_bytes[int'(send_slot) * SLOT_LEN + int'(send_pos)] : 8'h00;
            if (b != 8'h00) begin
                r.tx_byte  = take_byte(send_slot, send_pos);
                send_pos   = send_pos + 1'b1;
                r.tx_valid = 1'b1;
            end else begin
                if (msg_count != 0) msg_count = msg_count - 1'b1;
                send_pos  = '0;
                send_slot = next_slot(send_slot);
                if (msg_count == 0) begin
                    tx_active = 1'b0;
                end else begin
                    r.tx_byte  = take_byte(send_slot, '0);
                    send_pos   = POS_W'(1);
                    r.tx_valid = 1'b1;
                end
            end
        end
        r.busy_res     = tx_active;
        r.queued_count = msg_count;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // present one item, with an occasional gap ahead of it, and wait for acceptance
    task automatic send_item(utq_pkg::t_in_item it, bit fix, utq_pkg::t_out_item want);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge i_clk);
        end
        fixed_flag = fix;
        fixed_want = want;
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
    endtask

    // predict on every accepted item, check on every accepted result
    always @(posedge i_clk) begin : result_check
        utq_pkg::t_out_item exp_r;
        utq_pkg::t_out_item got;
        bit                 was_active;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                was_active = tx_active;
                if (int'(msg_count) >= NUM_SLOTS) full_hits++;
                exp_r = predict_tx_result(i_in_item);
                if (fixed_flag) exp_r = fixed_want;
                if (exp_r.dropped) drops_seen++;
                if (!((i_in_item.opcode == utq_pkg::OP_TX_DONE && !was_active) ||
                      exp_r.dropped))
                    useful_items++;
                pending_results.push_back(exp_r);
            end
            if (o_out_valid && i_out_ready) begin
                got = o_out_item;
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got.tx_valid !== exp_r.tx_valid)
                        report_mismatch($sformatf("tx_valid got %0b want %0b",
                                        got.tx_valid, exp_r.tx_valid));
                    if (got.tx_byte !== exp_r.tx_byte)
                        report_mismatch($sformatf("tx_byte got %02h want %02h",
                                        got.tx_byte, exp_r.tx_byte));
                    if (got.busy_res !== exp_r.busy_res)
                        report_mismatch($sformatf("busy_res got %0b want %0b",
                                        got.busy_res, exp_r.busy_res));
                    if (got.dropped !== exp_r.dropped)
                        report_mismatch($sformatf("dropped got %0b want %0b",
                                        got.dropped, exp_r.dropped));
                    if (got.queued_count !== exp_r.queued_count)
                        report_mismatch($sformatf("queued_count got %0d want %0d",
                                        got.queued_count, exp_r.queued_count));
                end
            end
        end
    end

    // receiver: short random stalls, one long hold-off on request, none when calm
    initial begin : receiver
        int n;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 99) < 15) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 3);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("FAIL uart_tx_message_queue");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        utq_pkg::t_in_item it;
        int                row;
        int                k;
        int                n;
        int                msg_left;
        int                done_pct;
        int                burst;
        int                r;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        fixed_flag = 1'b0;
        fixed_want = '0;
        useful_items = 0;
        results_seen = 0;
        drops_seen   = 0;
        full_hits    = 0;
        mismatches   = 0;
        foreach (ring_bytes[i]) ring_bytes[i] = 8'h00;
        send_slot   = '0;
        commit_slot = SLOT_W'(NUM_SLOTS - 1);
        msg_count   = '0;
        send_pos    = '0;
        fill_pos    = '0;
        tx_active   = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (row = 0; row < DIR_ROWS; row++) begin
            for (k = 0; k < int'(DIR_TABLE[row].reps); k++) begin
                it.opcode     = DIR_TABLE[row].op;
                it.char_value = DIR_TABLE[row].ch;
                it.last_char  = DIR_TABLE[row].last;
                send_item(it, DIR_TABLE[row].fixed, DIR_TABLE[row].want);
            end
        end

        // random messages with random tx-done pacing, plus some noise
        msg_left = 0;
        done_pct = 50;
        burst    = 0;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (burst == 0) begin
                r = $urandom_range(0, 2);
                done_pct = (r == 0) ? 15 : (r == 1) ? 50 : 85;
                burst = 60;
            end
            burst--;
            if (n == RAND_ITEMS / 3) hold_req = 1'b1;
            if (n >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;

            it.char_value = 8'($urandom_range(0, 255));
            it.last_char  = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 6) begin
                it.opcode = ($urandom_range(0, 1) != 0) ? utq_pkg::OP_TX_DONE :
                                                          utq_pkg::OP_LOAD;
            end else if ($urandom_range(0, 99) < done_pct) begin
                it.opcode = utq_pkg::OP_TX_DONE;
            end else begin
                if (msg_left == 0) begin
                    r = $urandom_range(0, 99);
                    msg_left = (r < 65) ? $urandom_range(1, 5) :
                               (r < 90) ? $urandom_range(6, 20) : $urandom_range(28, 45);
                end
                it.opcode = utq_pkg::OP_LOAD;
                if ($urandom_range(0, 11) == 0) it.char_value = 8'h00;
                else if (it.char_value == 8'h00) it.char_value = 8'($urandom_range(1, 255));
                it.last_char = (msg_left == 1);
                msg_left--;
            end
            send_item(it, 1'b0, '0);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // drain, then keep watching for anything unexpected
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered: directed edge cases and %0d random items, %0d items changed state",
                 RAND_ITEMS, useful_items);
        $display("%0d results checked, %0d loads dropped, ring found full on %0d items",
                 results_seen, drops_seen, full_hits);
        if (mismatches == 0) begin
            $display("PASS uart_tx_message_queue");
        end else begin
            $display("FAIL uart_tx_message_queue");
        end
        $finish;
    end

endmodule
